// ----- rtl/core/sdm_pkg.sv -----
// Types and constants used by the set-dueling monitor.
package sdm_pkg;

  localparam int unsigned IndexWidth    = 10;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 11;
  localparam int unsigned RoleWidth     = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexWidth-1:0] CfgConstituencySize = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgTeamSize         = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgLowCount         = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CfgHighCount        = 2'd3;

  // Register reset values.
  localparam logic [10:0] ConstituencySizeReset = 11'd64;
  localparam logic [9:0]  TeamSizeReset         = 10'd1;
  localparam logic [9:0]  LowCountReset         = 10'd512;
  localparam logic [9:0]  HighCountReset        = 10'd512;

  // Operation codes.
  localparam logic OpInit   = 1'b0;
  localparam logic OpAccess = 1'b1;

  // Bits of a stored role.
  localparam int unsigned RoleSampleBit = 0;
  localparam int unsigned RoleTeamBit   = 1;

  typedef struct packed {
    logic                  operation;
    logic [IndexWidth-1:0] entry_index;
  } in_t;

  typedef struct packed {
    logic is_sample;
    logic team;
    logic winner;
  } out_t;

endpackage

// ----- rtl/core/sdm_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module sdm_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/set_dueling_monitor.sv -----
// Set-dueling monitor: sample role store, region counter and saturating selector.
//
// Items enter on the in channel (valid/ready) and each gives one result on the
// out channel (valid/ready). An init item may give the entry a sample role from
// the rolling region counter; an access item looks up the role and, for a sample
// entry, moves the selector counter, which sets or clears the winner flag.
// A result passes through the lookup stage and the output register after its
// item is transferred. The block takes one item per cycle while the clearing
// pass is over and the receiver does not stall; that rate is set by the single
// role RAM read and at most one write per item, with a bypass for back-to-back
// updates of the same entry.
// A result waiting in the output register does not block the next transfer
// until the stage behind it is also full; a stalled receiver then holds the
// whole pipeline with no loss.
// After reset the role RAM is cleared one entry per cycle; in_ready_o stays low
// until the pass ends.
// Configuration writes are always accepted and must be issued only while the
// block is idle.
module set_dueling_monitor #(
  parameter int unsigned NUM_ENTRIES  = 1024,
  parameter int unsigned COUNTER_BITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  sdm_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output sdm_pkg::out_t                      out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sdm_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [sdm_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  localparam int unsigned AddrWidth = $clog2(NUM_ENTRIES);
  localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(NUM_ENTRIES - 1);
  localparam logic [COUNTER_BITS-1:0] SelMax = {COUNTER_BITS{1'b1}};
  localparam logic [COUNTER_BITS-1:0] SelMid = SelMax >> 1;
  localparam logic WinnerReset =
    (32'(SelMid) < 32'(sdm_pkg::LowCountReset)) ? 1'b0 : 1'b1;

  // Configuration registers.
  logic [10:0] cons_size_q;
  logic [9:0]  team_size_q;
  logic [9:0]  low_count_q;
  logic [9:0]  high_count_q;

  // Clearing pass.
  logic                 clr_busy_q;
  logic [AddrWidth-1:0] clr_addr_q;

  // Region and selector state.
  logic [9:0]              region_q, region_d;
  logic [COUNTER_BITS-1:0] sel_q, sel_d;
  logic                    winner_q, winner_d;

  // Lookup stage.
  logic                                s1_valid_q;
  logic                                s1_op_q;
  logic                                s1_idx_ok_q;
  logic [AddrWidth-1:0]                s1_addr_q;
  logic [sdm_pkg::RoleWidth-1:0]       s1_add_q;
  logic                                byp_hit_q;
  logic [sdm_pkg::RoleWidth-1:0]       byp_role_q;

  // Output register.
  logic          out_valid_q;
  sdm_pkg::out_t out_data_q;

  logic                          in_fire;
  logic                          s1_adv;
  logic                          s1_fire;
  logic                          in_idx_ok;
  logic [AddrWidth-1:0]          in_addr;
  logic [sdm_pkg::RoleWidth-1:0] in_add;
  logic [10:0]                   region_sum;
  logic [9:0]                    region_inc;
  logic [sdm_pkg::RoleWidth-1:0] rd_role;
  logic [sdm_pkg::RoleWidth-1:0] old_role;
  logic [sdm_pkg::RoleWidth-1:0] new_role;
  logic [sdm_pkg::RoleWidth-1:0] s1_role;
  logic                          s1_write;
  logic                          ram_we;
  logic [AddrWidth-1:0]          ram_waddr;
  logic [sdm_pkg::RoleWidth-1:0] ram_wdata;
  logic                          byp_hit_d;

  assign cfg_ready_o = 1'b1;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_idx_ok = 32'(in_data_i.entry_index) < 32'(NUM_ENTRIES);
  assign in_addr   = AddrWidth'(in_data_i.entry_index);

  // Role assigned by an init, from the region counter.
  assign region_sum = {1'b0, region_q} + {1'b0, team_size_q};
  assign region_inc = region_q + 10'd1;

  always_comb begin
    in_add = '0;
    if (region_q < team_size_q) begin
      in_add[sdm_pkg::RoleSampleBit] = 1'b1;
    end else if (region_sum >= cons_size_q) begin
      in_add[sdm_pkg::RoleSampleBit] = 1'b1;
      in_add[sdm_pkg::RoleTeamBit]   = 1'b1;
    end
  end

  always_comb begin
    region_d = region_q;
    if (in_fire && (in_data_i.operation == sdm_pkg::OpInit)) begin
      region_d = ({1'b0, region_inc} >= cons_size_q) ? 10'd0 : region_inc;
    end
  end

  // Lookup stage: take the read role or the bypass from the previous update, then add the init bits.
  assign old_role = byp_hit_q ? byp_role_q : rd_role;
  assign new_role = old_role | s1_add_q;
  assign s1_write = s1_fire && (s1_op_q == sdm_pkg::OpInit) && s1_idx_ok_q;

  always_comb begin
    s1_role = '0;
    if (s1_idx_ok_q) begin
      s1_role = (s1_op_q == sdm_pkg::OpInit) ? new_role : old_role;
    end
  end

  assign byp_hit_d = s1_valid_q && (s1_op_q == sdm_pkg::OpInit) && s1_idx_ok_q &&
                     (s1_addr_q == in_addr);

  always_comb begin
    sel_d    = sel_q;
    winner_d = winner_q;
    if (s1_fire && (s1_op_q == sdm_pkg::OpAccess) && s1_role[sdm_pkg::RoleSampleBit]) begin
      if (s1_role[sdm_pkg::RoleTeamBit]) begin
        if (sel_q != SelMax) begin
          sel_d = sel_q + COUNTER_BITS'(1);
        end
        if (32'(sel_d) >= 32'(high_count_q)) begin
          winner_d = 1'b1;
        end
      end else begin
        if (sel_q != '0) begin
          sel_d = sel_q - COUNTER_BITS'(1);
        end
        if (32'(sel_d) < 32'(low_count_q)) begin
          winner_d = 1'b0;
        end
      end
    end
  end

  // The write port serves the clearing pass first, then role updates.
  always_comb begin
    ram_we    = s1_write;
    ram_waddr = s1_addr_q;
    ram_wdata = new_role;
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end
  end

  sdm_ram #(
    .Width (sdm_pkg::RoleWidth),
    .Depth (NUM_ENTRIES)
  ) u_role_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_addr),
    .rdata_o (rd_role)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cons_size_q  <= sdm_pkg::ConstituencySizeReset;
      team_size_q  <= sdm_pkg::TeamSizeReset;
      low_count_q  <= sdm_pkg::LowCountReset;
      high_count_q <= sdm_pkg::HighCountReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sdm_pkg::CfgConstituencySize: cons_size_q  <= cfg_data_i;
        sdm_pkg::CfgTeamSize:         team_size_q  <= cfg_data_i[9:0];
        sdm_pkg::CfgLowCount:         low_count_q  <= cfg_data_i[9:0];
        sdm_pkg::CfgHighCount:        high_count_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      region_q    <= '0;
      sel_q       <= SelMid;
      winner_q    <= WinnerReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AddrWidth'(1);
        if (clr_addr_q == LastAddr) begin
          clr_busy_q <= 1'b0;
        end
      end
      region_q <= region_d;
      sel_q    <= sel_d;
      winner_q <= winner_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= in_data_i.operation;
      s1_idx_ok_q <= in_idx_ok;
      s1_addr_q   <= in_addr;
      s1_add_q    <= in_add;
      byp_hit_q   <= byp_hit_d;
      byp_role_q  <= new_role;
    end
    if (s1_fire) begin
      out_data_q.is_sample <= s1_role[sdm_pkg::RoleSampleBit];
      out_data_q.team      <= s1_role[sdm_pkg::RoleSampleBit] &
                              s1_role[sdm_pkg::RoleTeamBit];
      out_data_q.winner    <= winner_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
